### hdl/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants of the presence display qualifier.
// ----------------------------------------------------------------------------
package pdq_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int OUT_W     = 112;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE  = 3'd0,
        CFG_ON_WIN  = 3'd1,
        CFG_ON_THR  = 3'd2,
        CFG_OFF_WIN = 3'd3,
        CFG_OFF_THR = 3'd4
    } t_cfg_idx;

    localparam logic [7:0]  CH_LF   = 8'h0A;
    localparam logic [7:0]  CH_CR   = 8'h0D;
    localparam logic [15:0] LINE_ON  = 16'h4E4F;   // "ON", first byte low
    localparam logic [23:0] LINE_OFF = 24'h46464F; // "OFF", first byte low
    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [15:0] CNT_MAX  = 16'hFFFF;

    typedef struct packed {
        logic        enable;
        logic [15:0] on_win;
        logic [6:0]  on_thr;
        logic [15:0] off_win;
        logic [6:0]  off_thr;
    } t_cfg;

    typedef struct packed {
        logic accept;    // latch input item
        logic exec;      // line assembly / event push / initial report
        logic prune;     // history sweep step
        logic decide;    // display on/off decision
        logic div_init;  // load share division
        logic div_step;  // one quotient bit
        logic load_out;  // load result register
    } t_cmd;

    typedef struct packed {
        logic tick_en;    // enabled tick in flight
        logic sweep_done;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

### hdl/pdq_ctrl.sv
// ----------------------------------------------------------------------------
// pdq_ctrl
// Sequencer: accept, execute, sweep, decide, divide, deliver.
// ----------------------------------------------------------------------------
module pdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pdq_pkg::t_sts i_sts,
    output pdq_pkg::t_cmd o_cmd
);
    import pdq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_PRUNE = 7'b0000100,
        S_DEC   = 7'b0001000,
        S_DIVI  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = i_sts.tick_en ? S_PRUNE : S_DIVI;
            end
            S_PRUNE: begin
                o_cmd.prune = 1'b1;
                if (i_sts.sweep_done) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                o_cmd.load_out = i_sts.out_free;
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### hdl/pdq_datapath.sv
// ----------------------------------------------------------------------------
// pdq_datapath
// Line assembly, event history memory, window counters, decision, share
// divider and result register.
// ----------------------------------------------------------------------------
module pdq_datapath #(
    parameter int EVENT_DEPTH = 256,
    parameter int LINE_LIMIT  = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pdq_pkg::t_cfg             i_cfg,
    input  pdq_pkg::t_cmd             i_cmd,
    output pdq_pkg::t_sts             o_sts,
    input  logic                      i_kind,
    input  logic [7:0]                i_byte,
    input  logic [31:0]               i_now,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [pdq_pkg::OUT_W-1:0] o_out_data
);
    import pdq_pkg::*;

    localparam int PW = $clog2(EVENT_DEPTH);
    localparam int CW = $clog2(EVENT_DEPTH + 1);
    localparam int LW = $clog2(LINE_LIMIT);
    localparam int NW = CW + 7;
    localparam logic [PW-1:0] PTR_LAST = PW'(EVENT_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(EVENT_DEPTH);
    localparam logic [LW-1:0] LEN_LAST = LW'(LINE_LIMIT - 1);

    // input item
    logic        r_kind;
    logic [7:0]  r_byte;
    logic [31:0] r_now;

    // line assembly
    logic [LW-1:0] r_len;
    logic [23:0]   r_lhead;

    // history ring
    logic [32:0]   r_mem [EVENT_DEPTH];
    logic [32:0]   r_rd_data;
    logic [PW-1:0] r_head;
    logic [CW-1:0] r_count, r_ring_on;

    // display and window
    logic        r_disp, r_init_done, r_win_open, r_first_off_v;
    logic [31:0] r_win_start, r_first_off_t, r_on_time, r_off_time;
    logic [15:0] r_win_on, r_win_off;
    logic        r_changed;
    logic [31:0] r_change_time;

    // sweep
    logic [PW-1:0] r_rd_ptr, r_wr_ptr;
    logic [CW-1:0] r_issued, r_kept, r_kept_on;
    logic          r_rd_vld;

    // divider
    logic [NW-1:0] r_num;
    logic [6:0]    r_quo;
    logic [2:0]    r_bit;

    // result
    logic          r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // ---- line / push ----
    logic          is_lf, is_cr, line_on, line_off, push, full, old_on;
    logic [23:0]   lhead_add;
    logic [CW:0]   tail_w;
    logic [PW-1:0] tail;

    assign is_lf    = (r_byte == CH_LF);
    assign is_cr    = (r_byte == CH_CR);
    assign line_on  = (r_len == LW'(2)) && (r_lhead[15:0] == LINE_ON);
    assign line_off = (r_len == LW'(3)) && (r_lhead == LINE_OFF);
    assign push     = !r_kind && i_cfg.enable && is_lf && (line_on || line_off);
    assign full     = (r_count == DEPTH_C);
    assign old_on   = r_rd_data[32];

    always_comb begin
        case (r_len[1:0])
            2'd0:    lhead_add = {16'd0, r_byte};
            2'd1:    lhead_add = {8'd0, r_byte, 8'd0};
            default: lhead_add = {r_byte, 16'd0};
        endcase
        if ({1'b0, r_head} >= {1'b0, r_count})
            tail_w = {1'b0, r_head} - {1'b0, r_count};
        else
            tail_w = {1'b0, r_head} + (CW+1)'(EVENT_DEPTH) - {1'b0, r_count};
        tail = tail_w[PW-1:0];
    end

    // ---- sweep ----
    logic        ent_old, keep, issue;
    logic [31:0] ent_t;
    assign ent_t   = r_rd_data[31:0];
    assign ent_old = (ent_t <= r_now) && ((r_now - ent_t) > {16'd0, i_cfg.on_win});
    assign keep    = r_rd_vld && !ent_old;
    assign issue   = (r_issued != r_count);

    // ---- memory ----
    logic          mem_we;
    logic [PW-1:0] mem_wa, mem_ra;
    logic [32:0]   mem_wd;
    assign mem_we = (i_cmd.exec && push) || (i_cmd.prune && keep);
    assign mem_wa = i_cmd.prune ? r_wr_ptr : r_head;
    assign mem_wd = i_cmd.prune ? r_rd_data : {line_on, r_now};
    assign mem_ra = i_cmd.prune ? r_rd_ptr : r_head;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd_data <= r_mem[mem_ra];
    end

    // ---- decision ----
    logic [31:0] ws;
    logic        win_end, off_ok, on_ok;
    logic [16:0] win_sum;
    logic [23:0] off_lhs, off_rhs;
    logic [NW-1:0] on_lhs, on_rhs;

    assign ws      = r_win_open ? r_win_start : r_now;
    assign win_end = (ws <= r_now) && ((r_now - ws) >= {16'd0, i_cfg.off_win});
    assign win_sum = {1'b0, r_win_on} + {1'b0, r_win_off};
    assign off_lhs = 24'(r_win_on) * 24'(PCT_FULL);
    assign off_rhs = 24'(i_cfg.off_thr) * 24'(win_sum);
    assign off_ok  = (r_win_off != 16'd0) && (off_lhs <= off_rhs);
    assign on_lhs  = NW'(r_ring_on) * NW'(PCT_FULL);
    assign on_rhs  = NW'(i_cfg.on_thr) * NW'(r_count);
    assign on_ok   = on_lhs > on_rhs;

    // ---- divider ----
    logic [NW-1:0] trial;
    assign trial = NW'(r_count) << r_bit;

    // ---- status ----
    assign o_sts.tick_en    = r_kind && i_cfg.enable;
    assign o_sts.sweep_done = !issue && !r_rd_vld;
    assign o_sts.div_last   = (r_bit == 3'd0);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_byte <= i_byte;
            r_now  <= i_now;
        end
        if (i_cmd.div_init) begin
            r_num <= on_lhs;
            r_quo <= '0;
            r_bit <= 3'd6;
        end else if (i_cmd.div_step) begin
            if (r_num >= trial) begin
                r_num        <= r_num - trial;
                r_quo[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 3'd1;
        end
        if (i_cmd.load_out) begin
            r_out_data <= OUT_W'({r_off_time, r_on_time,
                                  (r_count == '0) ? 7'd0 : r_quo,
                                  r_change_time, r_changed, r_disp});
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len         <= '0;
            r_lhead       <= '0;
            r_head        <= '0;
            r_count       <= '0;
            r_ring_on     <= '0;
            r_disp        <= 1'b1;
            r_init_done   <= 1'b0;
            r_win_open    <= 1'b0;
            r_win_start   <= '0;
            r_win_on      <= '0;
            r_win_off     <= '0;
            r_first_off_v <= 1'b0;
            r_first_off_t <= '0;
            r_on_time     <= '0;
            r_off_time    <= '0;
            r_changed     <= 1'b0;
            r_change_time <= '0;
            r_rd_ptr      <= '0;
            r_wr_ptr      <= '0;
            r_issued      <= '0;
            r_kept        <= '0;
            r_kept_on     <= '0;
            r_rd_vld      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_changed     <= 1'b0;
                r_change_time <= '0;
            end

            if (i_cmd.exec) begin
                if (!r_kind) begin
                    if (i_cfg.enable) begin
                        if (is_lf) begin
                            r_len   <= '0;
                            r_lhead <= '0;
                            if (line_on && r_win_on != CNT_MAX)
                                r_win_on <= r_win_on + 16'd1;
                            if (line_off) begin
                                if (r_win_off != CNT_MAX) r_win_off <= r_win_off + 16'd1;
                                if (!r_first_off_v) begin
                                    r_first_off_v <= 1'b1;
                                    r_first_off_t <= r_now;
                                end
                            end
                            if (push) begin
                                r_head    <= ptr_inc(r_head);
                                r_count   <= full ? r_count : r_count + 1'b1;
                                r_ring_on <= r_ring_on - CW'(full && old_on)
                                             + CW'(line_on);
                            end
                        end else if (r_len < LEN_LAST) begin
                            if (!is_cr) begin
                                if (r_len < LW'(3)) r_lhead <= r_lhead | lhead_add;
                                r_len <= r_len + 1'b1;
                            end
                        end else begin
                            r_len   <= '0;
                            r_lhead <= '0;
                        end
                    end
                end else if (!i_cfg.enable) begin
                    if (!r_disp) begin
                        r_disp        <= 1'b1;
                        r_changed     <= 1'b1;
                        r_change_time <= r_now;
                    end
                end else begin
                    if (!r_init_done) begin
                        r_on_time     <= r_now;
                        r_init_done   <= 1'b1;
                        r_changed     <= 1'b1;
                        r_change_time <= r_now;
                    end
                    r_rd_ptr  <= tail;
                    r_wr_ptr  <= tail;
                    r_issued  <= '0;
                    r_kept    <= '0;
                    r_kept_on <= '0;
                    r_rd_vld  <= 1'b0;
                end
            end

            if (i_cmd.prune) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_issued <= r_issued + 1'b1;
                    r_rd_ptr <= ptr_inc(r_rd_ptr);
                end
                if (keep) begin
                    r_wr_ptr  <= ptr_inc(r_wr_ptr);
                    r_kept    <= r_kept + 1'b1;
                    r_kept_on <= r_kept_on + CW'(r_rd_data[32]);
                end
                if (!issue && !r_rd_vld) begin
                    r_count   <= r_kept;
                    r_ring_on <= r_kept_on;
                    r_head    <= r_wr_ptr;
                end
            end

            if (i_cmd.decide) begin
                if (r_disp) begin
                    if (win_end) begin
                        if (off_ok) begin
                            r_disp        <= 1'b0;
                            r_off_time    <= r_first_off_t;
                            r_changed     <= 1'b1;
                            r_change_time <= r_first_off_t;
                        end
                        r_win_open    <= 1'b0;
                        r_win_start   <= '0;
                        r_win_on      <= '0;
                        r_win_off     <= '0;
                        r_first_off_v <= 1'b0;
                        r_first_off_t <= '0;
                    end else begin
                        r_win_open  <= 1'b1;
                        r_win_start <= ws;
                    end
                end else if (on_ok) begin
                    r_disp        <= 1'b1;
                    r_on_time     <= r_now;
                    r_changed     <= 1'b1;
                    r_change_time <= r_now;
                    r_win_open    <= 1'b0;
                    r_win_start   <= '0;
                    r_win_on      <= '0;
                    r_win_off     <= '0;
                    r_first_off_v <= 1'b0;
                    r_first_off_t <= '0;
                end
            end

            if (i_cmd.load_out)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

endmodule

### hdl/presence_display_qualifier_unit.sv
// ----------------------------------------------------------------------------
// presence_display_qualifier_unit
// Qualifies a display on/off state from presence sensor text lines and ticks.
// ----------------------------------------------------------------------------
// One item is in work at a time and every item gives one result. A sensor
// byte or a disabled tick passes through execute, divider load, 7 quotient
// steps and result load. An enabled tick adds a sweep over the event history
// that reads one entry per cycle and writes survivors back behind the read
// pointer, plus a decision step. The ON share percentage is produced by a
// 7-step restoring divider. The result sits in an output register, so the
// next input transfer is taken while it waits.
// Configuration writes are always accepted and should only be made while the
// block is idle.
// ----------------------------------------------------------------------------
module presence_display_qualifier_unit #(
    parameter int EVENT_DEPTH = 256,  // history entries, 4..4096
    parameter int LINE_LIMIT  = 256   // line buffer limit, 4..256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pdq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pdq_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [39:0]                   i_s_tdata,  // [7:0] data_byte, [39:8] now_seconds
    input  logic                          i_s_tuser,  // [0] kind (1 = tick)
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] display_on, [1] changed, [33:2] change_time, [40:34] on_percent,
    // [72:41] last_on_time, [104:73] last_off_time, [111:105] zero
    output logic [pdq_pkg::OUT_W-1:0]     o_m_tdata
);
    import pdq_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;

    // configuration registers, written on each transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable  <= 1'b1;
            r_cfg.on_win  <= 16'd10;
            r_cfg.on_thr  <= 7'd50;
            r_cfg.off_win <= 16'd60;
            r_cfg.off_thr <= 7'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENABLE:  r_cfg.enable  <= i_cfg_data[0];
                CFG_ON_WIN:  r_cfg.on_win  <= i_cfg_data;
                CFG_ON_THR:  r_cfg.on_thr  <= i_cfg_data[6:0];
                CFG_OFF_WIN: r_cfg.off_win <= i_cfg_data;
                CFG_OFF_THR: r_cfg.off_thr <= i_cfg_data[6:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    pdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pdq_datapath #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .LINE_LIMIT  (LINE_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_s_tuser),
        .i_byte      (i_s_tdata[7:0]),
        .i_now       (i_s_tdata[39:8]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_data  (o_m_tdata)
    );

endmodule
